/* rtl/ecu_pkg.sv */
// Shared types, codes and constant-table generators for the easing curve unit.
// Depends on nothing; every other file of the block imports it.
package ecu_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;

    // Curve selector codes.
    localparam logic [3:0] FN_LINEAR        = 4'd0;
    localparam logic [3:0] FN_ELASTIC_IN    = 4'd1;
    localparam logic [3:0] FN_ELASTIC_OUT   = 4'd2;
    localparam logic [3:0] FN_ELASTIC_INOUT = 4'd3;
    localparam logic [3:0] FN_BOUNCE_IN     = 4'd4;
    localparam logic [3:0] FN_BOUNCE_OUT    = 4'd5;
    localparam logic [3:0] FN_BOUNCE_INOUT  = 4'd6;
    localparam logic [3:0] FN_BACK_IN       = 4'd7;
    localparam logic [3:0] FN_BACK_OUT      = 4'd8;
    localparam logic [3:0] FN_BACK_INOUT    = 4'd9;

    // Base curve that the back end evaluates.
    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_LINEAR,
        KIND_EIN,
        KIND_EOUT,
        KIND_BOUNCE,
        KIND_BACK
    } ecu_kind_t;

    // Offset added after the base curve.
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ONE,
        BASE_TWO
    } ecu_base_t;

    typedef struct packed {
        ecu_kind_t kind;
        ecu_base_t base;
        logic      neg;
        logic      half;
    } ecu_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ecu_queue_status_t;

    // Sine of x (Q30 radians) by Taylor series, rounded to fb fraction bits.
    function automatic logic [31:0] sine_entry(input logic [63:0] x, input int fb);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      e;
        longint      one;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        e   = longint'((64'(sum) + (64'd1 << (29 - fb))) >> (30 - fb));
        one = longint'(64'd1 << fb);
        if (e > one) begin
            e = one;
        end
        return 32'(e);
    endfunction

    // exp(y) for y in Q30 by Taylor series, rounded to fb fraction bits.
    function automatic logic [31:0] pow_entry(input logic [63:0] y, input int fb);
        logic [63:0] t;
        logic [63:0] s;
        t = 64'd1 << 30;
        s = t;
        t = ((t * y) >> 30) / 64'd1;  s = s + t;
        t = ((t * y) >> 30) / 64'd2;  s = s + t;
        t = ((t * y) >> 30) / 64'd3;  s = s + t;
        t = ((t * y) >> 30) / 64'd4;  s = s + t;
        t = ((t * y) >> 30) / 64'd5;  s = s + t;
        t = ((t * y) >> 30) / 64'd6;  s = s + t;
        t = ((t * y) >> 30) / 64'd7;  s = s + t;
        t = ((t * y) >> 30) / 64'd8;  s = s + t;
        t = ((t * y) >> 30) / 64'd9;  s = s + t;
        t = ((t * y) >> 30) / 64'd10; s = s + t;
        t = ((t * y) >> 30) / 64'd11; s = s + t;
        t = ((t * y) >> 30) / 64'd12; s = s + t;
        t = ((t * y) >> 30) / 64'd13; s = s + t;
        return 32'((s + (64'd1 << (29 - fb))) >> (30 - fb));
    endfunction

endpackage

/* rtl/ecu_front.sv */
// Front end: clamps progress and maps the curve selector onto a base curve,
// its argument and the offset, sign and halving applied afterwards. Uses ecu_pkg.
module ecu_front #(
    parameter int FRACTION_BITS = ecu_pkg::FRACTION_BITS_DEF
) (
    input  logic [3:0]               s_func,
    input  logic [FRACTION_BITS:0]   s_progress,
    output ecu_pkg::ecu_ctrl_t       ctrl,
    output logic [FRACTION_BITS:0]   arg
);
    import ecu_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int AW    = F + 1;
    localparam int ONE_I = 1 << F;

    logic [AW-1:0] p;
    logic [AW:0]   twop;
    logic          lower;

    always_comb begin
        p     = (s_progress > AW'(ONE_I)) ? AW'(ONE_I) : s_progress;
        twop  = {p, 1'b0};
        lower = twop < (AW + 1)'(ONE_I);
    end

    always_comb begin
        ctrl = '{kind: KIND_ZERO, base: BASE_ZERO, neg: 1'b0, half: 1'b0};
        arg  = '0;
        unique case (s_func)
            FN_LINEAR: begin
                ctrl.kind = KIND_LINEAR;
                arg       = p;
            end
            FN_ELASTIC_IN: begin
                ctrl.kind = KIND_EIN;
                arg       = p;
            end
            FN_ELASTIC_OUT: begin
                ctrl.kind = KIND_EOUT;
                arg       = p;
            end
            FN_ELASTIC_INOUT: begin
                ctrl.half = 1'b1;
                if (lower) begin
                    ctrl.kind = KIND_EIN;
                    arg       = AW'(twop);
                end else begin
                    ctrl.kind = KIND_EOUT;
                    ctrl.base = BASE_ONE;
                    arg       = AW'(twop - (AW + 1)'(ONE_I));
                end
            end
            FN_BOUNCE_IN: begin
                ctrl.kind = KIND_BOUNCE;
                ctrl.base = BASE_ONE;
                ctrl.neg  = 1'b1;
                arg       = AW'(ONE_I) - p;
            end
            FN_BOUNCE_OUT: begin
                ctrl.kind = KIND_BOUNCE;
                arg       = p;
            end
            FN_BOUNCE_INOUT: begin
                ctrl.kind = KIND_BOUNCE;
                ctrl.base = BASE_ONE;
                ctrl.half = 1'b1;
                if (lower) begin
                    ctrl.neg = 1'b1;
                    arg      = AW'((AW + 1)'(ONE_I) - twop);
                end else begin
                    arg      = AW'(twop - (AW + 1)'(ONE_I));
                end
            end
            FN_BACK_IN: begin
                ctrl.kind = KIND_BACK;
                arg       = p;
            end
            FN_BACK_OUT: begin
                ctrl.kind = KIND_BACK;
                ctrl.base = BASE_ONE;
                ctrl.neg  = 1'b1;
                arg       = AW'(ONE_I) - p;
            end
            FN_BACK_INOUT: begin
                ctrl.kind = KIND_BACK;
                ctrl.half = 1'b1;
                if (lower) begin
                    arg = AW'(twop);
                end else begin
                    ctrl.base = BASE_TWO;
                    ctrl.neg  = 1'b1;
                    arg       = AW'((AW + 1)'(2 * ONE_I) - twop);
                end
            end
            default: begin
                ctrl.kind = KIND_ZERO;
                arg       = '0;
            end
        endcase
    end

endmodule

/* rtl/ecu_queue.sv */
// Small register FIFO between the front end and the evaluation pipeline.
// Uses ecu_pkg for its status struct.
module ecu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ecu_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output ecu_pkg::ecu_queue_status_t status
);
    import ecu_pkg::*;

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    always_comb begin
        status.full  = (count_reg == CNW'(DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNW'(do_push) - CNW'(do_pop);
        pop_data   = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/ecu_back.sv */
// Evaluation pipeline: sine and power table lookups, interpolation, products,
// bounce quadratic, post offset, halving and saturation. Uses ecu_pkg.
module ecu_back #(
    parameter int FRACTION_BITS = ecu_pkg::FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = ecu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ecu_pkg::ecu_ctrl_t            q_ctrl,
    input  logic [FRACTION_BITS:0]        q_arg,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [FRACTION_BITS+1:0] m_eased
);
    import ecu_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int D     = TABLE_DEPTH;
    localparam int AW    = F + 1;
    localparam int SW    = F + 1;
    localparam int PW    = F + 2;
    localparam int IW    = $clog2(D + 1);
    localparam int PHW   = F + 5;
    localparam int MW    = F + 4;
    localparam int EW    = F + 3;
    localparam int BW    = F + 7;
    localparam int DMW   = F + 5;
    localparam int DDW   = 2 * DMW;
    localparam int VW    = F + 4;
    localparam int OW    = F + 2;
    localparam int PSW   = SW + F + 2;
    localparam int PEW   = PW + F + 2;
    localparam int PRW   = SW + 2 + EW + 1;
    localparam int ONE_I = 1 << F;

    // Constant tables.
    logic [SW-1:0] sine_rom [D + 1];
    logic [PW-1:0] pow_rom  [D + 1];

    for (genvar k = 0; k <= D; k++) begin : g_rom
        localparam logic [63:0] XK = (64'(k) * HALF_PI_Q30) / 64'(D);
        localparam logic [63:0] YK = (64'(k) * LN2_Q30) / 64'(D);
        assign sine_rom[k] = SW'(sine_entry(XK, F));
        assign pow_rom[k]  = PW'(pow_entry(YK, F));
    end

    logic       adv;
    logic [6:0] vld_reg;
    logic       m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign q_pop   = adv && q_valid;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[5:0], q_valid};
            m_valid_reg <= vld_reg[6];
        end
    end

    // Stage 1: angle, exponent split, squares' operands, bounce segment.
    ecu_ctrl_t     s1_ctrl_reg;
    logic [AW-1:0] s1_a_reg;

    logic [PHW-1:0]        phase;
    logic [1:0]            quad;
    logic [AW-1:0]         g;
    logic [AW+IW-1:0]      pos_s;
    logic [AW-1:0]         om;
    logic [MW-1:0]         mval;
    logic [F+IW-1:0]       pos_e;
    logic [F-1:0]          fe;
    logic [F+4:0]          t11;
    logic signed [BW-1:0]  a22;
    logic signed [BW-1:0]  d_full;
    logic [F-1:0]          k_next;
    logic [BW-1:0]         c_sel;

    logic                  s2_sgn_next;
    logic [IW-1:0]         s2_idx_s_next, s2_idx_e_next;
    logic [F-1:0]          s2_fr_s_next, s2_fr_e_next;
    logic [3:0]            s2_n_next;
    logic [2*AW-1:0]       s2_aa_next;
    logic [DMW-1:0]        s2_dm_next;

    always_comb begin
        if (s1_ctrl_reg.kind == KIND_EIN) begin
            phase = PHW'(s1_a_reg) * PHW'(13);
        end else if (s1_ctrl_reg.kind == KIND_EOUT) begin
            phase = PHW'(s1_a_reg) * PHW'(13) + PHW'(13 * ONE_I);
        end else begin
            phase = PHW'(s1_a_reg) << 1;
        end
        quad          = phase[F+1:F];
        g             = quad[0] ? AW'(ONE_I) - {1'b0, phase[F-1:0]} : {1'b0, phase[F-1:0]};
        pos_s         = (AW + IW)'(g) * (AW + IW)'(D);
        s2_sgn_next   = quad[1];
        s2_idx_s_next = pos_s[F +: IW];
        s2_fr_s_next  = pos_s[F-1:0];

        om            = (s1_ctrl_reg.kind == KIND_EIN) ? AW'(ONE_I) - s1_a_reg : s1_a_reg;
        mval          = MW'(om) * MW'(10);
        s2_n_next     = mval[F+3:F] + 4'(|mval[F-1:0]);
        fe            = F'(0) - mval[F-1:0];
        pos_e         = (F + IW)'(fe) * (F + IW)'(D);
        s2_idx_e_next = pos_e[F +: IW];
        s2_fr_e_next  = pos_e[F-1:0];

        s2_aa_next    = (2 * AW)'(s1_a_reg) * (2 * AW)'(s1_a_reg);

        t11 = (F + 5)'(s1_a_reg) * (F + 5)'(11);
        a22 = $signed(BW'(s1_a_reg) * BW'(22));
        if (t11 < (F + 5)'(4 * ONE_I)) begin
            c_sel  = '0;
            k_next = '0;
        end else if (t11 < (F + 5)'(8 * ONE_I)) begin
            c_sel  = BW'(12 * ONE_I);
            k_next = F'((3 * ONE_I) / 4);
        end else if (t11 < (F + 5)'(10 * ONE_I)) begin
            c_sel  = BW'(18 * ONE_I);
            k_next = F'((15 * ONE_I) / 16);
        end else begin
            c_sel  = BW'(21 * ONE_I);
            k_next = F'((63 * ONE_I) / 64);
        end
        d_full     = a22 - $signed(c_sel);
        s2_dm_next = d_full[BW-1] ? DMW'(-d_full) : DMW'(d_full);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctrl_reg <= q_ctrl;
            s1_a_reg    <= q_arg;
        end
    end

    // Stage 2: table reads, rounded square, bounce square.
    ecu_ctrl_t       s2_ctrl_reg;
    logic [AW-1:0]   s2_a_reg;
    logic            s2_sgn_reg;
    logic [IW-1:0]   s2_idx_s_reg, s2_idx_e_reg;
    logic [F-1:0]    s2_fr_s_reg, s2_fr_e_reg;
    logic [3:0]      s2_n_reg;
    logic [2*AW-1:0] s2_aa_reg;
    logic [DMW-1:0]  s2_dm_reg;
    logic [F-1:0]    s2_k_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_ctrl_reg  <= s1_ctrl_reg;
            s2_a_reg     <= s1_a_reg;
            s2_sgn_reg   <= s2_sgn_next;
            s2_idx_s_reg <= s2_idx_s_next;
            s2_idx_e_reg <= s2_idx_e_next;
            s2_fr_s_reg  <= s2_fr_s_next;
            s2_fr_e_reg  <= s2_fr_e_next;
            s2_n_reg     <= s2_n_next;
            s2_aa_reg    <= s2_aa_next;
            s2_dm_reg    <= s2_dm_next;
            s2_k_reg     <= k_next;
        end
    end

    logic [IW-1:0]  idx_s_hi;
    logic [SW-1:0]  s3_sa_next, s3_sb_next;
    logic [PW-1:0]  s3_ea_next, s3_eb_next;
    logic [AW-1:0]  s3_sq_next;
    logic [DDW-1:0] s3_dd_next;
    logic [2*AW-1:0] aa_rnd;

    always_comb begin
        // The top entry is reached only at a quarter-wave peak, where the weight is zero.
        idx_s_hi   = (s2_idx_s_reg == IW'(D)) ? s2_idx_s_reg : s2_idx_s_reg + 1'b1;
        s3_sa_next = sine_rom[s2_idx_s_reg];
        s3_sb_next = sine_rom[idx_s_hi];
        s3_ea_next = pow_rom[s2_idx_e_reg];
        s3_eb_next = pow_rom[s2_idx_e_reg + 1'b1];
        aa_rnd     = s2_aa_reg + (2 * AW)'(ONE_I / 2);
        s3_sq_next = AW'(aa_rnd >> F);
        s3_dd_next = DDW'(s2_dm_reg) * DDW'(s2_dm_reg);
    end

    // Stage 3: interpolation products, cube product, bounce value.
    ecu_ctrl_t      s3_ctrl_reg;
    logic [AW-1:0]  s3_a_reg;
    logic           s3_sgn_reg;
    logic [SW-1:0]  s3_sa_reg, s3_sb_reg;
    logic [PW-1:0]  s3_ea_reg, s3_eb_reg;
    logic [F-1:0]   s3_fr_s_reg, s3_fr_e_reg;
    logic [3:0]     s3_n_reg;
    logic [AW-1:0]  s3_sq_reg;
    logic [DDW-1:0] s3_dd_reg;
    logic [F-1:0]   s3_k_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_a_reg    <= s2_a_reg;
            s3_sgn_reg  <= s2_sgn_reg;
            s3_sa_reg   <= s3_sa_next;
            s3_sb_reg   <= s3_sb_next;
            s3_ea_reg   <= s3_ea_next;
            s3_eb_reg   <= s3_eb_next;
            s3_fr_s_reg <= s2_fr_s_reg;
            s3_fr_e_reg <= s2_fr_e_reg;
            s3_n_reg    <= s2_n_reg;
            s3_sq_reg   <= s3_sq_next;
            s3_dd_reg   <= s3_dd_next;
            s3_k_reg    <= s2_k_reg;
        end
    end

    logic signed [SW:0]    diff_s;
    logic signed [PW:0]    diff_e;
    logic signed [PSW-1:0] s4_prod_s_next;
    logic signed [PEW-1:0] s4_prod_e_next;
    logic [2*AW-1:0]       s4_cube_raw_next;
    logic [DDW:0]          dd_rnd;
    logic [F+1:0]          s4_bnc_next;

    always_comb begin
        diff_s           = $signed({1'b0, s3_sb_reg}) - $signed({1'b0, s3_sa_reg});
        diff_e           = $signed({1'b0, s3_eb_reg}) - $signed({1'b0, s3_ea_reg});
        s4_prod_s_next   = diff_s * $signed({1'b0, s3_fr_s_reg});
        s4_prod_e_next   = diff_e * $signed({1'b0, s3_fr_e_reg});
        s4_cube_raw_next = (2 * AW)'(s3_sq_reg) * (2 * AW)'(s3_a_reg);
        dd_rnd           = (DDW + 1)'(s3_dd_reg) + ((DDW + 1)'(1) << (F + 5));
        s4_bnc_next      = (F + 2)'(dd_rnd >> (F + 6)) + (F + 2)'(s3_k_reg);
    end

    // Stage 4: finish interpolation, power shift, rounded cube.
    ecu_ctrl_t             s4_ctrl_reg;
    logic [AW-1:0]         s4_a_reg;
    logic                  s4_sgn_reg;
    logic [SW-1:0]         s4_sa_reg;
    logic [PW-1:0]         s4_ea_reg;
    logic signed [PSW-1:0] s4_prod_s_reg;
    logic signed [PEW-1:0] s4_prod_e_reg;
    logic [3:0]            s4_n_reg;
    logic [2*AW-1:0]       s4_cube_raw_reg;
    logic [F+1:0]          s4_bnc_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_ctrl_reg     <= s3_ctrl_reg;
            s4_a_reg        <= s3_a_reg;
            s4_sgn_reg      <= s3_sgn_reg;
            s4_sa_reg       <= s3_sa_reg;
            s4_ea_reg       <= s3_ea_reg;
            s4_prod_s_reg   <= s4_prod_s_next;
            s4_prod_e_reg   <= s4_prod_e_next;
            s4_n_reg        <= s3_n_reg;
            s4_cube_raw_reg <= s4_cube_raw_next;
            s4_bnc_reg      <= s4_bnc_next;
        end
    end

    logic [PSW-1:0]       mag_s;
    logic [PEW-1:0]       mag_e;
    logic signed [SW:0]   rnd_s;
    logic signed [PW:0]   rnd_e;
    logic signed [SW+1:0] sine_mag;
    logic signed [SW+1:0] s5_sine_next;
    logic signed [PW+1:0] base_e;
    logic [EW-1:0]        halfn;
    logic [EW-1:0]        e_sum;
    logic [EW-1:0]        s5_e_next;
    logic [2*AW-1:0]      cube_rnd;
    logic [AW-1:0]        s5_cube_next;

    always_comb begin
        // Rounded shifts go to nearest with ties away from zero, on the magnitude.
        mag_s        = s4_prod_s_reg[PSW-1] ? PSW'(-s4_prod_s_reg) : PSW'(s4_prod_s_reg);
        rnd_s        = $signed((SW + 1)'((mag_s + PSW'(ONE_I / 2)) >> F));
        rnd_s        = s4_prod_s_reg[PSW-1] ? -rnd_s : rnd_s;
        mag_e        = s4_prod_e_reg[PEW-1] ? PEW'(-s4_prod_e_reg) : PEW'(s4_prod_e_reg);
        rnd_e        = $signed((PW + 1)'((mag_e + PEW'(ONE_I / 2)) >> F));
        rnd_e        = s4_prod_e_reg[PEW-1] ? -rnd_e : rnd_e;
        sine_mag     = $signed({2'b00, s4_sa_reg}) + (SW + 2)'(rnd_s);
        s5_sine_next = s4_sgn_reg ? -sine_mag : sine_mag;
        base_e       = $signed({2'b00, s4_ea_reg}) + (PW + 2)'(rnd_e);
        halfn        = (s4_n_reg == 4'd0) ? '0 : (EW'(1) << (s4_n_reg - 4'd1));
        e_sum        = EW'(base_e) + halfn;
        s5_e_next    = e_sum >> s4_n_reg;
        cube_rnd     = s4_cube_raw_reg + (2 * AW)'(ONE_I / 2);
        s5_cube_next = AW'(cube_rnd >> F);
    end

    // Stage 5: the shared product (sine times power, or progress times sine).
    ecu_ctrl_t            s5_ctrl_reg;
    logic [AW-1:0]        s5_a_reg;
    logic signed [SW+1:0] s5_sine_reg;
    logic [EW-1:0]        s5_e_reg;
    logic [AW-1:0]        s5_cube_reg;
    logic [F+1:0]         s5_bnc_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_ctrl_reg <= s4_ctrl_reg;
            s5_a_reg    <= s4_a_reg;
            s5_sine_reg <= s5_sine_next;
            s5_e_reg    <= s5_e_next;
            s5_cube_reg <= s5_cube_next;
            s5_bnc_reg  <= s4_bnc_reg;
        end
    end

    logic [EW-1:0]         opb;
    logic signed [PRW-1:0] s6_prod_next;

    always_comb begin
        opb          = (s5_ctrl_reg.kind == KIND_BACK) ? EW'(s5_a_reg) : s5_e_reg;
        s6_prod_next = s5_sine_reg * $signed({1'b0, opb});
    end

    // Stage 6: round the product and pick the base curve value.
    ecu_ctrl_t             s6_ctrl_reg;
    logic [AW-1:0]         s6_a_reg;
    logic signed [PRW-1:0] s6_prod_reg;
    logic [AW-1:0]         s6_cube_reg;
    logic [F+1:0]          s6_bnc_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_ctrl_reg <= s5_ctrl_reg;
            s6_a_reg    <= s5_a_reg;
            s6_prod_reg <= s6_prod_next;
            s6_cube_reg <= s5_cube_reg;
            s6_bnc_reg  <= s5_bnc_reg;
        end
    end

    logic [PRW-1:0]       mag_p;
    logic signed [VW-1:0] mr;
    logic signed [VW-1:0] s7_v_next;

    always_comb begin
        mag_p = s6_prod_reg[PRW-1] ? PRW'(-s6_prod_reg) : PRW'(s6_prod_reg);
        mr    = $signed(VW'((mag_p + PRW'(ONE_I / 2)) >> F));
        mr    = s6_prod_reg[PRW-1] ? -mr : mr;
        unique case (s6_ctrl_reg.kind)
            KIND_ZERO:   s7_v_next = '0;
            KIND_LINEAR: s7_v_next = $signed(VW'(s6_a_reg));
            KIND_EIN:    s7_v_next = mr;
            KIND_EOUT:   s7_v_next = $signed(VW'(ONE_I)) - mr;
            KIND_BOUNCE: s7_v_next = $signed(VW'(s6_bnc_reg));
            KIND_BACK:   s7_v_next = $signed(VW'(s6_cube_reg)) - mr;
            default:     s7_v_next = '0;
        endcase
    end

    // Stage 7: offset, sign, halving and saturation into the output register.
    ecu_ctrl_t            s7_ctrl_reg;
    logic signed [VW-1:0] s7_v_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_ctrl_reg <= s6_ctrl_reg;
            s7_v_reg    <= s7_v_next;
        end
    end

    logic signed [VW:0]   base_v;
    logic signed [VW:0]   t;
    logic [VW:0]          tm;
    logic [VW:0]          rr;
    logic signed [VW+1:0] r;
    logic signed [OW-1:0] m_eased_reg, m_eased_next;

    always_comb begin
        unique case (s7_ctrl_reg.base)
            BASE_ZERO: base_v = '0;
            BASE_ONE:  base_v = $signed((VW + 1)'(ONE_I));
            BASE_TWO:  base_v = $signed((VW + 1)'(2 * ONE_I));
            default:   base_v = '0;
        endcase
        t  = s7_ctrl_reg.neg ? base_v - (VW + 1)'(s7_v_reg) : base_v + (VW + 1)'(s7_v_reg);
        tm = t[VW] ? (VW + 1)'(-t) : (VW + 1)'(t);
        rr = s7_ctrl_reg.half ? (tm + 1'b1) >> 1 : tm;
        r  = t[VW] ? -$signed({1'b0, rr}) : $signed({1'b0, rr});
        if (r < -$signed((VW + 2)'(2 * ONE_I))) begin
            m_eased_next = $signed(OW'(-(2 * ONE_I)));
        end else if (r > $signed((VW + 2)'(2 * ONE_I - 1))) begin
            m_eased_next = $signed(OW'(2 * ONE_I - 1));
        end else begin
            m_eased_next = OW'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_eased_reg <= m_eased_next;
        end
    end

    assign m_eased = m_eased_reg;

endmodule

/* rtl/easing_curve_unit.sv */
// Top level of the easing curve unit: front end, queue and evaluation pipeline.
// Depends on ecu_pkg, ecu_front, ecu_queue and ecu_back.
//
//   Channel   Ports                           Direction  Content
//   input     s_valid s_ready s_func s_progress  in       curve code, Q1.F progress
//   result    m_valid m_ready m_eased            out      eased value, signed Q2.F
//
// One item per cycle is taken and one result per cycle is delivered while
// m_ready stays high; the figure is set by the eight-register evaluation
// pipeline, which advances in every cycle that m_ready is high. An item goes
// from its input transfer into the queue and then through s1 to s7 of the
// pipeline to the output register.
// Reset is synchronous and active low; it empties the queue and clears every
// stage valid bit. The tables are constant logic and need no fill.
// A stalled result freezes the whole pipeline; the front keeps accepting until
// the four-entry queue is full, and s_ready then drops.
module easing_curve_unit #(
    parameter int FRACTION_BITS = ecu_pkg::FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = ecu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_func,
    input  logic [FRACTION_BITS:0]          s_progress,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [FRACTION_BITS+1:0] m_eased
);
    import ecu_pkg::*;

    localparam int AW = FRACTION_BITS + 1;
    localparam int QW = $bits(ecu_ctrl_t) + AW;

    ecu_ctrl_t         f_ctrl;
    logic [AW-1:0]     f_arg;
    ecu_ctrl_t         q_ctrl;
    logic [AW-1:0]     q_arg;
    logic [QW-1:0]     q_out;
    ecu_queue_status_t q_stat;
    logic              q_push;
    logic              q_pop;

    // The front classifies each item combinationally on the way into the queue.
    ecu_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .s_func    (s_func),
        .s_progress(s_progress),
        .ctrl      (f_ctrl),
        .arg       (f_arg)
    );

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    // The queue decouples acceptance from the pipeline, so a stall on the
    // result side does not stop input transfers until the queue fills.
    ecu_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({f_ctrl, f_arg}),
        .pop      (q_pop),
        .pop_data (q_out),
        .status   (q_stat)
    );

    assign {q_ctrl, q_arg} = q_out;

    // The pipeline takes the queue head whenever it advances.
    ecu_back #(
        .FRACTION_BITS(FRACTION_BITS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(!q_stat.empty),
        .q_ctrl (q_ctrl),
        .q_arg  (q_arg),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_eased(m_eased)
    );

    // The pipeline never pops an empty queue.
    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    // A result waiting on the output keeps the queue head in place.
    a_stall_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !q_pop)
        else $error("queue popped while the result is stalled");

    // An input transfer always lands in the queue.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !q_stat.empty)
        else $error("accepted item missing from queue");

endmodule
